// ===== rtl/swmn_pkg.sv =====
// ----------------------------------------------------------------------------
// swmn_pkg
// Shared types and constants for the sliding-window M-of-N warner.
// ----------------------------------------------------------------------------
package swmn_pkg;

  localparam int WINDOW_MAX_DEF = 16;

  localparam int CNT_W   = 8;   // detection count
  localparam int DIST_W  = 16;  // signed distance
  localparam int HIT_W   = 4;   // hit count
  localparam int WLEN_W  = 4;   // window_len register
  localparam int WARN_W  = 4;   // warn_threshold register
  localparam int NDIST_W = 15;  // near/mid distance registers
  localparam int LVL_W   = 2;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [HIT_W-1:0] HIT_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_DIST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MID_DIST   = 3'd4;

  // warning levels
  localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
  localparam logic [LVL_W-1:0] LVL_FAR  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_MID  = 2'd2;
  localparam logic [LVL_W-1:0] LVL_NEAR = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_FILL,
    OP_STEADY
  } op_t;

  // one-cycle commands to the window cells, raised on input transaction
  typedef struct packed {
    logic clear;
    logic fill;
    logic steady;
  } cell_cmd_t;

endpackage

// ===== rtl/swmn_cell.sv =====
// ----------------------------------------------------------------------------
// swmn_cell
// One window slot: holds a detection count, shifts toward slot 0, and adds
// its hit bit to the running hit sum that ripples along the chain.
// ----------------------------------------------------------------------------
module swmn_cell #(
  parameter int IDX  = 0,
  parameter int LN_W = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  swmn_pkg::cell_cmd_t       cmd,
  input  logic [LN_W-1:0]           len,
  input  logic [LN_W-1:0]           slot,
  input  logic [swmn_pkg::CNT_W-1:0] din,
  input  logic [swmn_pkg::CNT_W-1:0] up_entry,
  input  logic [swmn_pkg::CNT_W-1:0] det_thr,
  input  logic [swmn_pkg::HIT_W-1:0] psum_in,
  output logic [swmn_pkg::CNT_W-1:0] entry,
  output logic [swmn_pkg::HIT_W-1:0] psum_out
);
  import swmn_pkg::*;

  localparam logic [LN_W-1:0] MY_IDX = LN_W'(IDX);

  logic [CNT_W-1:0] entry_r, entry_nxt;
  logic [HIT_W-1:0] psum_r, psum_nxt;
  logic             hit;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.clear) begin
      entry_nxt = '0;
    end else if (cmd.fill && slot == MY_IDX) begin
      entry_nxt = din;
    end else if (cmd.steady && (MY_IDX + LN_W'(1)) == len) begin
      // new count lands at the window end and shifts down in the same step
      entry_nxt = din;
    end else if (cmd.steady && MY_IDX < len) begin
      entry_nxt = up_entry;
    end else if (cmd.steady && MY_IDX == len) begin
      entry_nxt = din;
    end
  end

  // only slots below the window length take part in the recount
  assign hit = (MY_IDX < len) && (entry_r >= det_thr);

  always_comb begin
    if (psum_in == HIT_MAX) begin
      psum_nxt = HIT_MAX;
    end else begin
      psum_nxt = psum_in + HIT_W'(hit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      psum_r  <= '0;
    end else begin
      entry_r <= entry_nxt;
      psum_r  <= psum_nxt;
    end
  end

  assign entry    = entry_r;
  assign psum_out = psum_r;

endmodule

// ===== rtl/sliding_window_m_of_n_warner_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_m_of_n_warner_unit
// M-of-N sliding-window detector with distance-banded warning level.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per sweep. in_tuser = action (1 clears the window
//           store and hit count). One result transaction per input on out_*.
//   cfg_* : register writes, index 0..4 (window_len, detect_threshold,
//           warn_threshold, near_dist, mid_dist); always ready. Write only
//           while no sweep is in flight.
//   Sequencing: a clear or a fill-phase sweep goes from ST_IDLE straight to
//   ST_FIN and its result then enters the output register; a steady-phase
//   sweep first waits in ST_COUNT while the hit sum ripples once through the
//   chain of WINDOW_MAX window cells. A new sweep is accepted the cycle after
//   the previous result is loaded, so the unit takes no new sweep while one
//   is still in flight.
//   The result register holds its data while out_tready is low; a finished
//   result waits in the control sequencer until the register frees up.
//   Reset: registers return to their defaults, window, hit count, sweep count
//   and flag are zero, and the output register is empty.
// ----------------------------------------------------------------------------
module sliding_window_m_of_n_warner_unit #(
  parameter int WINDOW_MAX = swmn_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // [7:0] detect_count, [23:8] distance_m, [24] stop, [31:25] zero
  input  logic [swmn_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] action
  input  logic                                in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] warn_flag, [2:1] warn_level, [6:3] hits_in_window, [7] zero
  output logic [swmn_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swmn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swmn_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import swmn_pkg::*;

  localparam int LN_W  = $clog2(WINDOW_MAX + 1);
  localparam int CTR_W = $clog2(WINDOW_MAX);
  localparam logic [LN_W-1:0]  LEN_CAP  = LN_W'(WINDOW_MAX - 1);
  localparam logic [LN_W-1:0]  SWP_SAT  = LN_W'(WINDOW_MAX);
  localparam logic [CTR_W-1:0] CTR_LAST = CTR_W'(WINDOW_MAX - 1);

  // configuration
  logic [WLEN_W-1:0]  window_len_r;
  logic [CNT_W-1:0]   detect_thr_r;
  logic [WARN_W-1:0]  warn_thr_r;
  logic [NDIST_W-1:0] near_dist_r;
  logic [NDIST_W-1:0] mid_dist_r;

  // control and state
  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [CTR_W-1:0]   ctr_r, ctr_nxt;
  logic [LN_W-1:0]    sweep_cnt_r, sweep_cnt_nxt;
  logic [HIT_W-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic               flag_r, flag_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIST_W-1:0]  dist_r;
  logic               stop_r;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic               in_xact;
  logic               load_out;
  logic               cnt_done;
  logic [LN_W-1:0]    len;
  cell_cmd_t          cmd;

  logic [CNT_W-1:0]   entry_w [WINDOW_MAX];
  logic [HIT_W-1:0]   psum_w  [WINDOW_MAX];

  logic [HIT_W-1:0]   hits_fill;
  logic [HIT_W-1:0]   hits_res;
  logic               flag_res;
  logic [LVL_W-1:0]   lvl_res;

  // effective window length
  always_comb begin
    if (32'(window_len_r) >= 32'(WINDOW_MAX)) begin
      len = LEN_CAP;
    end else begin
      len = LN_W'(window_len_r);
    end
  end

  assign in_xact = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    op_nxt = op_r;
    if (in_xact) begin
      if (in_tuser) begin
        op_nxt = OP_CLEAR;
      end else if (sweep_cnt_r < len) begin
        op_nxt = OP_FILL;
      end else begin
        op_nxt = OP_STEADY;
      end
    end
  end

  assign cmd.clear  = in_xact && (op_nxt == OP_CLEAR);
  assign cmd.fill   = in_xact && (op_nxt == OP_FILL);
  assign cmd.steady = in_xact && (op_nxt == OP_STEADY);

  // window cells
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [CNT_W-1:0] up_entry;
    logic [HIT_W-1:0] psum_in;
    if (i == WINDOW_MAX - 1) begin : g_top
      assign up_entry = '0;
    end else begin : g_mid
      assign up_entry = entry_w[i+1];
    end
    if (i == 0) begin : g_first
      assign psum_in = '0;
    end else begin : g_rest
      assign psum_in = psum_w[i-1];
    end
    swmn_cell #(
      .IDX  (i),
      .LN_W (LN_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .len      (len),
      .slot     (sweep_cnt_r),
      .din      (in_tdata[CNT_W-1:0]),
      .up_entry (up_entry),
      .det_thr  (detect_thr_r),
      .psum_in  (psum_in),
      .entry    (entry_w[i]),
      .psum_out (psum_w[i])
    );
  end

  // result of the sweep in flight
  always_comb begin
    if (hit_cnt_r == HIT_MAX) begin
      hits_fill = HIT_MAX;
    end else begin
      hits_fill = hit_cnt_r + HIT_W'(cnt_r >= detect_thr_r);
    end
  end

  always_comb begin
    case (op_r)
      OP_CLEAR: begin
        hits_res = '0;
        flag_res = flag_r;
      end
      OP_FILL: begin
        hits_res = hits_fill;
        flag_res = flag_r || (hits_fill >= warn_thr_r);
      end
      OP_STEADY: begin
        hits_res = psum_w[WINDOW_MAX-1];
        flag_res = (psum_w[WINDOW_MAX-1] >= warn_thr_r);
      end
      default: begin
        hits_res = hit_cnt_r;
        flag_res = flag_r;
      end
    endcase
  end

  always_comb begin
    lvl_res = LVL_NONE;
    if (op_r != OP_CLEAR && flag_res && !stop_r && !dist_r[DIST_W-1]) begin
      if (dist_r[NDIST_W-1:0] <= near_dist_r) begin
        lvl_res = LVL_NEAR;
      end else if (dist_r[NDIST_W-1:0] <= mid_dist_r) begin
        lvl_res = LVL_MID;
      end else begin
        lvl_res = LVL_FAR;
      end
    end
  end

  // sequencer: next state
  assign cnt_done = (ctr_r == CTR_LAST);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xact) begin
          state_nxt = (op_nxt == OP_STEADY) ? ST_COUNT : ST_FIN;
        end
      end
      ST_COUNT: begin
        if (cnt_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    load_out      = (state_r == ST_FIN) && (!out_valid_r || out_tready);
    ctr_nxt       = (state_r == ST_COUNT) ? ctr_r + CTR_W'(1) : '0;
    sweep_cnt_nxt = sweep_cnt_r;
    hit_cnt_nxt   = hit_cnt_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (in_xact && op_nxt != OP_CLEAR && sweep_cnt_r != SWP_SAT) begin
      sweep_cnt_nxt = sweep_cnt_r + LN_W'(1);
    end
    if (load_out) begin
      hit_cnt_nxt   = hits_res;
      flag_nxt      = flag_res;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, hits_res, lvl_res, flag_res};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= OP_CLEAR;
      ctr_r        <= '0;
      sweep_cnt_r  <= '0;
      hit_cnt_r    <= '0;
      flag_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      window_len_r <= WLEN_W'(5);
      detect_thr_r <= CNT_W'(1);
      warn_thr_r   <= WARN_W'(3);
      near_dist_r  <= NDIST_W'(100);
      mid_dist_r   <= NDIST_W'(300);
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      ctr_r       <= ctr_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LEN: window_len_r <= cfg_data[WLEN_W-1:0];
          REG_DETECT_THR: detect_thr_r <= cfg_data[CNT_W-1:0];
          REG_WARN_THR:   warn_thr_r   <= cfg_data[WARN_W-1:0];
          REG_NEAR_DIST:  near_dist_r  <= cfg_data[NDIST_W-1:0];
          REG_MID_DIST:   mid_dist_r   <= cfg_data[NDIST_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_xact) begin
      cnt_r  <= in_tdata[CNT_W-1:0];
      dist_r <= in_tdata[CNT_W +: DIST_W];
      stop_r <= in_tdata[CNT_W + DIST_W];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
